### sv/asfc_pkg.sv
// Shared codes, types and constants for the audio sample format converter.
package asfc_pkg;

	// Format codes held in the source and destination registers
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S16 = 3'd1;
	localparam logic [2:0] FMT_S32 = 3'd2;
	localparam logic [2:0] FMT_S64 = 3'd3;
	localparam logic [2:0] FMT_F32 = 3'd4;
	localparam logic [2:0] FMT_F64 = 3'd5;

	// Width of the internal signed binary exponent
	localparam int EXP_W = 13;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_NORM,
		CLS_INF
	} cls_t;

	// Side information that travels with each item down the pipeline
	typedef struct packed {
		logic        valid;
		logic        last;
		logic        sign;
		cls_t        cls;
		logic        direct;
		logic [63:0] dval;
	} meta_t;

endpackage

### sv/asfc_decode.sv
// Decode stage: unpacks the source sample and resolves the direct cases.
module asfc_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [2:0]                        src_fmt,
	input  logic [2:0]                        dst_fmt,
	input  logic                              valid_s1,
	input  logic                              last_s1,
	input  logic [63:0]                       sample_s1,
	output asfc_pkg::meta_t                   meta_s2,
	output logic [63:0]                       word_s2,
	output logic signed [asfc_pkg::EXP_W-1:0] exp_s2
);
	import asfc_pkg::*;

	meta_t                    meta;
	logic [63:0]              word;
	logic signed [EXP_W-1:0]  expv;
	logic [63:0]              aligned;
	logic [63:0]              mag;
	logic [63:0]              q;
	logic [63:0]              ires;
	logic [5:0]               sh;
	logic                     drop;
	logic                     f32_nan;
	logic                     f32_inf;
	logic                     f64_nan;
	logic                     f64_inf;

	// Integer source placed at the top of a 64-bit word, value = aligned / 2^63
	always_comb begin
		case (src_fmt)
			FMT_U8:  aligned = {~sample_s1[7], sample_s1[6:0], 56'd0};
			FMT_S16: aligned = {sample_s1[15:0], 48'd0};
			FMT_S32: aligned = {sample_s1[31:0], 32'd0};
			default: aligned = sample_s1;
		endcase
		mag = aligned[63] ? (~aligned + 64'd1) : aligned;
	end

	// Integer to integer: arithmetic shift, corrected toward zero
	always_comb begin
		case (dst_fmt)
			FMT_U8:  sh = 6'd56;
			FMT_S16: sh = 6'd48;
			FMT_S32: sh = 6'd32;
			default: sh = 6'd0;
		endcase
		drop = |(aligned & ~({64{1'b1}} << sh));
		q = ($signed(aligned) >>> sh) + {63'd0, aligned[63] & drop};
		case (dst_fmt)
			FMT_U8:  ires = {56'd0, q[7:0] ^ 8'h80};
			FMT_S16: ires = {48'd0, q[15:0]};
			FMT_S32: ires = {32'd0, q[31:0]};
			default: ires = q;
		endcase
	end

	assign f32_nan = (sample_s1[30:23] == 8'hFF) && (sample_s1[22:0] != 23'd0);
	assign f32_inf = (sample_s1[30:23] == 8'hFF) && (sample_s1[22:0] == 23'd0);
	assign f64_nan = (sample_s1[62:52] == 11'h7FF) && (sample_s1[51:0] != 52'd0);
	assign f64_inf = (sample_s1[62:52] == 11'h7FF) && (sample_s1[51:0] == 52'd0);

	// Classify and unpack; value = sign * word * 2^(expv - 63)
	always_comb begin
		meta       = '0;
		meta.valid = valid_s1;
		meta.last  = last_s1;
		word       = 64'd0;
		expv       = '0;
		if ((src_fmt > FMT_F64) || (dst_fmt > FMT_F64)) begin
			meta.direct = 1'b1;
		end else if (src_fmt <= FMT_S64) begin
			meta.sign = aligned[63];
			meta.cls  = (mag == 64'd0) ? CLS_ZERO : CLS_NORM;
			word      = mag;
			if (dst_fmt <= FMT_S64) begin
				meta.direct = 1'b1;
				meta.dval   = ires;
			end
		end else if (src_fmt == FMT_F32) begin
			meta.sign = sample_s1[31];
			if (sample_s1[30:23] == 8'd0) begin
				meta.cls = (sample_s1[22:0] == 23'd0) ? CLS_ZERO : CLS_NORM;
				expv     = -EXP_W'(126);
			end else begin
				meta.cls = f32_inf ? CLS_INF : CLS_NORM;
				expv     = EXP_W'(sample_s1[30:23]) - EXP_W'(127);
			end
			word = {(sample_s1[30:23] != 8'd0), sample_s1[22:0], 40'd0};
			if (dst_fmt == FMT_F32) begin
				meta.direct = 1'b1;
				meta.dval   = {32'd0, sample_s1[31:0]};
			end else if (f32_nan) begin
				// quiet NaN for a float64 destination, payload kept in the top fraction bits; zero for integers
				meta.direct = 1'b1;
				if (dst_fmt == FMT_F64) begin
					meta.dval = {sample_s1[31], 11'h7FF, 52'd0} | 64'h0008_0000_0000_0000
						| {12'd0, sample_s1[22:0], 29'd0};
				end
			end
		end else begin
			meta.sign = sample_s1[63];
			// subnormal doubles are far below every other target's resolution
			if (sample_s1[62:52] == 11'd0) begin
				meta.cls = CLS_ZERO;
			end else begin
				meta.cls = f64_inf ? CLS_INF : CLS_NORM;
			end
			expv = EXP_W'(sample_s1[62:52]) - EXP_W'(1023);
			word = {1'b1, sample_s1[51:0], 11'd0};
			if (dst_fmt == FMT_F64) begin
				meta.direct = 1'b1;
				meta.dval   = sample_s1;
			end else if (f64_nan) begin
				meta.direct = 1'b1;
				if (dst_fmt == FMT_F32) begin
					meta.dval = {32'd0, sample_s1[63], 8'hFF, 1'b1 | sample_s1[51],
						sample_s1[50:29]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
		end else begin
			meta_s2 <= meta;
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= word;
		exp_s2  <= expv;
	end

endmodule

### sv/asfc_norm.sv
// Normalizer: leading-one search, left shift, then round to 53 bits.
module asfc_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  asfc_pkg::meta_t                   meta_s2,
	input  logic [63:0]                       word_s2,
	input  logic signed [asfc_pkg::EXP_W-1:0] exp_s2,
	output asfc_pkg::meta_t                   meta_s5,
	output logic [52:0]                       man_s5,
	output logic signed [asfc_pkg::EXP_W-1:0] exp_s5
);
	import asfc_pkg::*;

	logic [5:0]              lz;
	meta_t                   meta_s3;
	meta_t                   meta_s4;
	logic [63:0]             word_s3;
	logic [5:0]              lz_s3;
	logic signed [EXP_W-1:0] exp_s3;
	logic [63:0]             man_s4;
	logic signed [EXP_W-1:0] exp_s4;
	logic                    up;
	logic [53:0]             sum54;

	// Leading zero count
	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (word_s2[i]) begin
				lz = 6'(63 - i);
			end
		end
	end

	// Round to nearest even at 53 bits
	assign up    = man_s4[10] & ((|man_s4[9:0]) | man_s4[11]);
	assign sum54 = {1'b0, man_s4[63:11]} + 54'(up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
		end else begin
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
		end
	end

	always_ff @(posedge clk) begin
		word_s3 <= word_s2;
		lz_s3   <= lz;
		exp_s3  <= exp_s2;
		man_s4  <= word_s3 << lz_s3;
		exp_s4  <= exp_s3 - EXP_W'(lz_s3);
		if (sum54[53]) begin
			man_s5 <= {1'b1, 52'd0};
			exp_s5 <= exp_s4 + EXP_W'(1);
		end else begin
			man_s5 <= sum54[52:0];
			exp_s5 <= exp_s4;
		end
	end

endmodule

### sv/asfc_encode.sv
// Encode stage: packs the normalized value into the destination format.
module asfc_encode (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [2:0]                        dst_fmt,
	input  asfc_pkg::meta_t                   meta_s5,
	input  logic [52:0]                       man_s5,
	input  logic signed [asfc_pkg::EXP_W-1:0] exp_s5,
	output logic                              done_q,
	output logic [63:0]                       sample_q,
	output logic                              last_q
);
	import asfc_pkg::*;

	localparam logic signed [EXP_W-1:0] E_ZERO  = 0;
	localparam logic signed [EXP_W-1:0] E_64    = 64;
	localparam logic signed [EXP_W-1:0] E_97    = 97;
	localparam logic signed [EXP_W-1:0] E_55    = 55;
	localparam logic signed [EXP_W-1:0] F32_MIN = -126;
	localparam logic signed [EXP_W-1:0] F32_MAX = 127;

	logic [63:0]             res;
	logic [63:0]             f64_bits;
	logic [31:0]             f32_bits;
	logic signed [EXP_W-1:0] e32;
	logic signed [EXP_W-1:0] nsh;
	logic signed [EXP_W-1:0] ash;
	logic signed [EXP_W-1:0] bsh;
	logic [5:0]              rr;
	logic [55:0]             m56;
	logic [55:0]             q56;
	logic                    guard;
	logic                    stk;
	logic                    rup;
	logic [24:0]             q25;
	logic [7:0]              base8;
	logic [30:0]             bits31;
	logic [63:0]             wv;
	logic [63:0]             imag;
	logic [63:0]             sres;
	logic [63:0]             yt;
	logic                    yst;
	logic [61:0]             s62;
	logic [3:0]              k;
	logic                    u8up;
	logic [8:0]              q9;
	logic [7:0]              u8r;
	logic                    ge1;
	logic                    sat;

	assign wv  = {man_s5, 11'd0};
	assign ge1 = (exp_s5 >= E_ZERO);
	assign sat = (meta_s5.cls == CLS_INF) || ge1;

	// Double precision pack
	assign f64_bits = {meta_s5.sign, 11'(exp_s5 + EXP_W'(1023)), man_s5[51:0]};

	// Single precision with subnormals, round to nearest even
	always_comb begin
		e32 = exp_s5 + EXP_W'(127);
		nsh = -(exp_s5 + E_97);
		if (exp_s5 >= F32_MIN) begin
			rr = 6'd29;
		end else if (nsh >= E_55) begin
			rr = 6'd55;
		end else begin
			rr = nsh[5:0];
		end
		m56    = {3'd0, man_s5};
		q56    = m56 >> rr;
		guard  = m56[rr - 6'd1];
		stk    = |(m56 & ((56'd1 << (rr - 6'd1)) - 56'd1));
		rup    = guard & (stk | q56[0]);
		q25    = {1'b0, q56[23:0]} + 25'(rup);
		base8  = (exp_s5 >= F32_MIN) ? 8'(e32 - EXP_W'(1)) : 8'd0;
		bits31 = {base8, 23'd0} + 31'(q25);
		if ((exp_s5 > F32_MAX) || (bits31 >= 31'h7F80_0000)) begin
			f32_bits = {meta_s5.sign, 31'h7F80_0000};
		end else begin
			f32_bits = {meta_s5.sign, bits31};
		end
	end

	// Signed integer: truncate the scaled magnitude
	always_comb begin
		case (dst_fmt)
			FMT_S16: ash = EXP_W'(48) - exp_s5;
			FMT_S32: ash = EXP_W'(32) - exp_s5;
			default: ash = E_ZERO - exp_s5;
		endcase
		imag = (ash >= E_64) ? 64'd0 : (wv >> ash[5:0]);
		sres = meta_s5.sign ? (~imag + 64'd1) : imag;
	end

	// Offset binary: t*128 + 128 rounded in double precision, then truncated
	always_comb begin
		bsh = EXP_W'(2) - exp_s5;
		if (bsh >= E_64) begin
			yt  = 64'd0;
			yst = 1'b1;
		end else begin
			yt  = wv >> bsh[5:0];
			yst = |(wv & ~({64{1'b1}} << bsh[5:0]));
		end
		if (meta_s5.sign) begin
			s62 = (62'd128 << 54) - (62'(yt) + 62'(yst));
		end else begin
			s62 = (62'd128 << 54) + 62'(yt);
		end
		k = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (s62[54 + i]) begin
				k = 4'(i + 1);
			end
		end
		u8up = &(s62[53:0] | ((54'd1 << k) - 54'd1));
		q9   = {1'b0, s62[61:54]} + 9'(u8up);
		u8r  = q9[8] ? 8'hFF : q9[7:0];
	end

	// Destination select
	always_comb begin
		if (meta_s5.direct) begin
			res = meta_s5.dval;
		end else begin
			case (dst_fmt)
				FMT_F64: begin
					if (meta_s5.cls == CLS_ZERO) begin
						res = {meta_s5.sign, 63'd0};
					end else if (meta_s5.cls == CLS_INF) begin
						res = {meta_s5.sign, 11'h7FF, 52'd0};
					end else begin
						res = f64_bits;
					end
				end
				FMT_F32: begin
					if (meta_s5.cls == CLS_ZERO) begin
						res = {32'd0, meta_s5.sign, 31'd0};
					end else if (meta_s5.cls == CLS_INF) begin
						res = {32'd0, meta_s5.sign, 31'h7F80_0000};
					end else begin
						res = {32'd0, f32_bits};
					end
				end
				FMT_U8: begin
					if (meta_s5.cls == CLS_ZERO) begin
						res = 64'h80;
					end else if (sat) begin
						res = meta_s5.sign ? 64'd0 : 64'hFF;
					end else begin
						res = {56'd0, u8r};
					end
				end
				FMT_S16: begin
					if (meta_s5.cls == CLS_ZERO) begin
						res = 64'd0;
					end else if (sat) begin
						res = meta_s5.sign ? 64'h8000 : 64'h7FFF;
					end else begin
						res = {48'd0, sres[15:0]};
					end
				end
				FMT_S32: begin
					if (meta_s5.cls == CLS_ZERO) begin
						res = 64'd0;
					end else if (sat) begin
						res = meta_s5.sign ? 64'h8000_0000 : 64'h7FFF_FFFF;
					end else begin
						res = {32'd0, sres[31:0]};
					end
				end
				FMT_S64: begin
					if (meta_s5.cls == CLS_ZERO) begin
						res = 64'd0;
					end else if (sat) begin
						res = meta_s5.sign ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
					end else begin
						res = sres;
					end
				end
				default: res = 64'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= meta_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		sample_q <= res;
		last_q   <= meta_s5.last;
	end

endmodule

### sv/audio_sample_format_converter.sv
// Top level of the audio sample format converter.
// Converts one sample per clock between u8, s16, s32, s64, float32 and float64.
// busy is always low, so an item is taken on every cycle start is high. Each
// result appears on sample_out and last_out for one cycle with done high, after
// passing through the six registers of the pipeline (input, decode,
// leading-one search, shift, 53-bit rounding, encode). Results cannot be held
// off, so the receiver must take each one when done is high. The user must
// write formats through the cfg port (index 0 source, index 1 destination) only
// while no item is in flight; the block does not enforce this. Both reset to s16.
module audio_sample_format_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] sample_in,
	input  logic        last_in,
	output logic        done,
	output logic [63:0] sample_out,
	output logic        last_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);
	import asfc_pkg::*;

	localparam logic [1:0] CFG_SRC = 2'd0;
	localparam logic [1:0] CFG_DST = 2'd1;

	logic [2:0]              source_format_q;
	logic [2:0]              dest_format_q;
	logic                    valid_s1;
	logic                    last_s1;
	logic [63:0]             sample_s1;
	meta_t                   meta_s2;
	logic [63:0]             word_s2;
	logic signed [EXP_W-1:0] exp_s2;
	meta_t                   meta_s5;
	logic [52:0]             man_s5;
	logic signed [EXP_W-1:0] exp_s5;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Format registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_S16;
			dest_format_q   <= FMT_S16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SRC: source_format_q <= cfg_data;
				CFG_DST: dest_format_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= sample_in;
		last_s1   <= last_in;
	end

	asfc_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_fmt   (source_format_q),
		.dst_fmt   (dest_format_q),
		.valid_s1  (valid_s1),
		.last_s1   (last_s1),
		.sample_s1 (sample_s1),
		.meta_s2   (meta_s2),
		.word_s2   (word_s2),
		.exp_s2    (exp_s2)
	);

	asfc_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.meta_s2 (meta_s2),
		.word_s2 (word_s2),
		.exp_s2  (exp_s2),
		.meta_s5 (meta_s5),
		.man_s5  (man_s5),
		.exp_s5  (exp_s5)
	);

	asfc_encode u_encode (
		.clk      (clk),
		.arst_n   (arst_n),
		.dst_fmt  (dest_format_q),
		.meta_s5  (meta_s5),
		.man_s5   (man_s5),
		.exp_s5   (exp_s5),
		.done_q   (done),
		.sample_q (sample_out),
		.last_q   (last_out)
	);

	// Every accepted item comes out with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done)
		else $error("accepted item did not produce a result");

	// The buffer marker follows its own sample
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_in, 6)))
		else $error("last_out does not match its item");

	// A float32 destination keeps the upper bits clear
	a_f32_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (dest_format_q == FMT_F32)) |-> (sample_out[63:32] == 32'd0))
		else $error("float32 result has upper bits set");

endmodule
